// ===== hw/rtl/bpr_pkg.sv =====
// ----------------------------------------------------------------------------
// bpr_pkg: shared types and constants of the byte pattern replacer
// Sizes, register indexes, the configuration bundle and the command word
// that travels from the front end to the output sequencer.
// ----------------------------------------------------------------------------
package bpr_pkg;

   // Longest search or replacement pattern, in bytes (1 to 8).
   localparam int MAX_BYTES = 8;
   // Length fields of the registers are 4 bits wide.
   localparam int LEN_W = 4;
   localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

   localparam int PAT_W = 64;
   localparam int LIMIT_W = 32;

   // Command queue between front end and output sequencer.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Configuration port.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_OLD_PATTERN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OLD_LENGTH       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_PATTERN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_LENGTH       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CASE_SENSITIVE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REPLACEMENTS = 3'd5;

   // Result sideband bits in rsp_tuser.
   localparam int USER_W = 3;

   typedef struct packed {
      logic [PAT_W-1:0]   old_pattern;
      logic [LEN_W-1:0]   old_length;
      logic [PAT_W-1:0]   new_pattern;
      logic [LEN_W-1:0]   new_length;
      logic               case_sensitive;
      logic [LIMIT_W-1:0] max_replacements;
   } bpr_cfg_type;

   // One group of output bytes that share their flags.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;     // byte 0 goes out first
      logic [LEN_W-1:0]          count;     // 1 .. MAX_BYTES
      logic                      replaced;
      logic                      limit;
      logic                      last;      // group ends the run of its input
      logic                      done;      // group ends the stream
   } bpr_cmd_type;

endpackage

// ===== hw/rtl/bpr_front.sv =====
// ----------------------------------------------------------------------------
// bpr_front: window, matcher and replacement counter
// Accepts input bytes into the window and, while the queue has room, compares
// the window front with the search pattern and pushes at most one group per cycle.
// ----------------------------------------------------------------------------
module bpr_front import bpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  bpr_cfg_type cfg,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   output logic        push_valid,
   output bpr_cmd_type push_cmd,
   input  logic        q_full
);

   typedef enum logic {ST_ACCEPT, ST_BUSY} state_type;

   state_type          state_ff, state_in;
   logic [7:0]         win_ff [MAX_BYTES];
   logic [7:0]         win_in [MAX_BYTES];
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic               eos_ff, eos_in;
   logic [LIMIT_W-1:0] rcount_ff, rcount_in;
   logic               limit_ff, limit_in;

   logic [7:0]       cur [MAX_BYTES];
   logic [7:0]       rep [MAX_BYTES];
   logic [7:0]       shf [MAX_BYTES];
   logic [LEN_W-1:0] cur_fill, len, step, rest;
   logic [LEN_W:0]   src;
   logic [7:0]       nb;
   logic             cur_eos, enable, take, work, iter, match, blocked, hit, skip, cont;

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return is_upper(c) ? (c + 8'd32) : c;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
   endfunction

   always_comb begin
      enable = (cfg.old_length != '0) && (cfg.old_length <= LEN_W'(MAX_BYTES)) &&
               (cfg.new_length != '0) && (cfg.new_length <= cfg.old_length);
      len = enable ? cfg.old_length : LEN_W'(1);

      req_tready = (state_ff == ST_ACCEPT) && !q_full;
      take = req_tready && req_tvalid;
      work = take || ((state_ff == ST_BUSY) && !q_full);

      // Append the incoming byte, or keep working on the held window.
      if (state_ff == ST_ACCEPT) begin
         for (int i = 0; i < MAX_BYTES; i++) begin
            cur[i] = (fill_ff == LEN_W'(i)) ? req_tdata : win_ff[i];
         end
         cur_fill = fill_ff + LEN_W'(1);
         cur_eos = req_tlast;
      end else begin
         cur = win_ff;
         cur_fill = fill_ff;
         cur_eos = eos_ff;
      end

      iter = (cur_fill != '0) && (cur_fill >= len);

      match = enable;
      for (int i = 0; i < MAX_BYTES; i++) begin
         if (LEN_W'(i) < len) begin
            if (cfg.case_sensitive) begin
               if (cur[i] != cfg.old_pattern[8*i +: 8]) match = 1'b0;
            end else begin
               if (to_lower(cur[i]) != to_lower(cfg.old_pattern[8*i +: 8])) match = 1'b0;
            end
         end
      end

      blocked = (cfg.max_replacements != '0) && (rcount_ff >= cfg.max_replacements);
      hit = iter && match && !blocked;
      skip = iter && match && blocked;

      // Overwrite the start of the match, copying letter case if asked.
      nb = '0;
      for (int i = 0; i < MAX_BYTES; i++) begin
         if (LEN_W'(i) < cfg.new_length) begin
            nb = cfg.new_pattern[8*i +: 8];
            if (!cfg.case_sensitive) begin
               nb = is_upper(cur[i]) ? to_upper(nb) : to_lower(nb);
            end
            rep[i] = nb;
         end else begin
            rep[i] = cur[i];
         end
      end

      // Drop the sent bytes off the window front.
      step = hit ? len : LEN_W'(1);
      src = '0;
      for (int i = 0; i < MAX_BYTES; i++) begin
         src = (LEN_W+1)'(i) + {1'b0, step};
         shf[i] = (src < (LEN_W+1)'(MAX_BYTES)) ? cur[src[IDX_W-1:0]] : cur[i];
      end

      if (iter) begin
         rest = cur_fill - step;
      end else if (cur_eos) begin
         rest = '0;
      end else begin
         rest = cur_fill;
      end
      cont = iter && (rest != '0) && (rest >= len);

      push_valid = work && (iter || (cur_eos && (cur_fill != '0)));
      for (int i = 0; i < MAX_BYTES; i++) begin
         push_cmd.bytes[i] = hit ? rep[i] : cur[i];
      end
      push_cmd.count = iter ? step : cur_fill;
      push_cmd.replaced = hit;
      push_cmd.limit = limit_ff | skip;
      push_cmd.last = iter ? (!cont && (!cur_eos || (rest == '0))) : 1'b1;
      push_cmd.done = push_cmd.last && cur_eos;

      state_in = state_ff;
      win_in = win_ff;
      fill_in = fill_ff;
      eos_in = eos_ff;
      rcount_in = rcount_ff;
      limit_in = limit_ff;
      if (work) begin
         // Stay busy while more groups or a flush remain for this transfer.
         state_in = (cont || (iter && cur_eos && (rest != '0))) ? ST_BUSY : ST_ACCEPT;
         if (iter) begin
            win_in = shf;
         end else begin
            win_in = cur;
         end
         fill_in = rest;
         eos_in = cur_eos;
         rcount_in = rcount_ff + LIMIT_W'(hit);
         limit_in = limit_ff | skip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         fill_ff <= '0;
         eos_ff <= 1'b0;
         rcount_ff <= '0;
         limit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         eos_ff <= eos_in;
         rcount_ff <= rcount_in;
         limit_ff <= limit_in;
      end
      win_ff <= win_in;
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push_valid)
      else $error("front pushed into a full queue");

   a_room_to_append: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCEPT) |-> (fill_ff < LEN_W'(MAX_BYTES)))
      else $error("window full while accepting");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> ((push_cmd.count != '0) && (push_cmd.count <= LEN_W'(MAX_BYTES))))
      else $error("pushed group with bad byte count");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_cmd.done) |-> push_cmd.last)
      else $error("stream end on a group that does not end its run");

endmodule

// ===== hw/rtl/bpr_queue.sv =====
// ----------------------------------------------------------------------------
// bpr_queue: command queue
// Short first-in first-out buffer of output groups between the front end
// and the output sequencer; the head is visible without a pop.
// ----------------------------------------------------------------------------
module bpr_queue import bpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  bpr_cmd_type push_cmd,
   output logic        q_full,
   input  logic        pop,
   output bpr_cmd_type head,
   output logic        q_empty
);

   bpr_cmd_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   always_comb begin
      q_full = (cnt_ff == QCNT_W'(QDEPTH));
      q_empty = (cnt_ff == '0);
      head = mem_ff[rd_ff];
      do_push = push_valid && !q_full;
      do_pop = pop && !q_empty;

      wr_in = wr_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
      end
      rd_in = rd_ff;
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
      end
      cnt_in = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/bpr_back.sv =====
// ----------------------------------------------------------------------------
// bpr_back: output sequencer
// Walks the bytes of the queue head into the result register one per cycle
// while rsp is not stalled, and pops the group after its final byte.
// ----------------------------------------------------------------------------
module bpr_back import bpr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  bpr_cmd_type       head,
   input  logic              q_empty,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic [USER_W-1:0] rsp_tuser
);

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]        rsp_tdata_ff, rsp_tdata_in;
   logic              rsp_tlast_ff, rsp_tlast_in;
   logic [USER_W-1:0] rsp_tuser_ff, rsp_tuser_in;
   logic [LEN_W-1:0]  pos_next;
   logic              emit, final_byte;

   always_comb begin
      emit = !q_empty && (!rsp_tvalid_ff || rsp_tready);
      pos_next = LEN_W'(idx_ff) + LEN_W'(1);
      final_byte = (pos_next == head.count);
      pop = emit && final_byte;

      idx_in = idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tlast_in = rsp_tlast_ff;
      rsp_tuser_in = rsp_tuser_ff;
      if (emit) begin
         idx_in = final_byte ? '0 : idx_ff + IDX_W'(1);
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in = head.bytes[idx_ff];
         rsp_tlast_in = final_byte && head.last;
         rsp_tuser_in = {head.limit, head.replaced, final_byte && head.done};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tlast = rsp_tlast_ff;
   assign rsp_tuser = rsp_tuser_ff;

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("pop from an empty queue");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> (idx_ff == '0))
      else $error("byte index left over with empty queue");

   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (LEN_W'(idx_ff) < head.count))
      else $error("byte index beyond group");

   a_done_with_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("stream end without run end");

endmodule

// ===== hw/rtl/byte_pattern_replacer_core.sv =====
// ----------------------------------------------------------------------------
// byte_pattern_replacer_core: streaming search and replace of one pattern
// Replaces the leftmost non-overlapping occurrences of a configured byte
// pattern, optionally case-insensitive, with a sticky replacement limit.
//
//   Channel   Direction  Payload
//   req_*     in         tdata = data_byte, tlast = end_of_stream
//   rsp_*     out        tdata = out_byte, tlast = last_of_run,
//                        tuser = {limit_reached, was_replaced, stream_done}
//   csr_*     in         wen, index (register number), wdata
//
// One input byte per cycle is taken while the front end is not busy and the
// command queue has room; the front end compares the window once per cycle,
// and the output sequencer sends one byte per cycle unless rsp is stalled.
// End of stream adds a front-end flush step when the final compare leaves
// bytes behind; a window left from longer settings drains one group per
// cycle, while the queue has room, before the next transfer.
// An input transfer reaches rsp through a queue entry, then the result register.
// Synchronous reset clears control state and loads register defaults.
// A stalled rsp side fills the four-entry queue, then req_tready drops.
// ----------------------------------------------------------------------------
module byte_pattern_replacer_core import bpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_byte
   output logic                  rsp_tlast,
   output logic [USER_W-1:0]     rsp_tuser,   // [0] stream_done [1] was_replaced
                                              // [2] limit_reached
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   bpr_cfg_type cfg_ff, cfg_in;
   bpr_cmd_type push_cmd, head;
   logic        push_valid, q_full, q_empty, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_OLD_PATTERN:      cfg_in.old_pattern = csr_wdata[PAT_W-1:0];
            CSR_OLD_LENGTH:       cfg_in.old_length = csr_wdata[LEN_W-1:0];
            CSR_NEW_PATTERN:      cfg_in.new_pattern = csr_wdata[PAT_W-1:0];
            CSR_NEW_LENGTH:       cfg_in.new_length = csr_wdata[LEN_W-1:0];
            CSR_CASE_SENSITIVE:   cfg_in.case_sensitive = csr_wdata[0];
            CSR_MAX_REPLACEMENTS: cfg_in.max_replacements = csr_wdata[LIMIT_W-1:0];
            default: begin
               // drop writes to unused indexes
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.old_pattern <= '0;
         cfg_ff.old_length <= '0;
         cfg_ff.new_pattern <= '0;
         cfg_ff.new_length <= '0;
         cfg_ff.case_sensitive <= 1'b1;
         cfg_ff.max_replacements <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bpr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .q_full     (q_full)
   );

   bpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .q_full     (q_full),
      .pop        (pop),
      .head       (head),
      .q_empty    (q_empty)
   );

   bpr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_empty    (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== verif/byte_pattern_replacer_core_tb.sv =====
// ----------------------------------------------------------------------------
// byte_pattern_replacer_core_tb: self-checking bench for the pattern replacer
// Streams bytes into the core under random valid and ready gaps, predicts
// every output byte and its flags with a software window of the same size,
// and checks each output transfer in order. Settings change only between
// phases, once the core has drained. Directed phases cover the disabled reset
// settings, exact and case-folding matches, the limit flag and full-length patterns.
// Random phases follow with biased, pattern-rich streams.
// ----------------------------------------------------------------------------
module byte_pattern_replacer_core_tb;
   import bpr_pkg::*;

   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_ITEMS   = 40;

   typedef struct packed {
      logic [7:0] data;
      logic       eos;
      logic       hold;   // wait for all due output bytes before sending
   } in_byte_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       done;
      logic       replaced;
      logic       limit;
   } out_byte_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;   // [7:0] data_byte
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;         // [7:0] out_byte
   logic                  rsp_tlast;
   logic [USER_W-1:0]     rsp_tuser;         // [0] stream_done [1] was_replaced
                                             // [2] limit_reached
   logic                  csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Mirror of the register file
   logic [PAT_W-1:0]   cfg_old_pat   = '0;
   logic [LEN_W-1:0]   cfg_old_len   = '0;
   logic [PAT_W-1:0]   cfg_new_pat   = '0;
   logic [LEN_W-1:0]   cfg_new_len   = '0;
   logic               cfg_case_sens = 1'b1;
   logic [LIMIT_W-1:0] cfg_max_repl  = '0;

   // Mirror of the search window and counters
   logic [7:0]         win_bytes [MAX_BYTES];
   int                 win_fill   = 0;
   logic [LIMIT_W-1:0] repl_count = '0;
   logic               limit_flag = 1'b0;

   in_byte_type  in_bytes_queued [$];
   out_byte_type out_bytes_due [$];
   out_byte_type due_out;

   int   errors       = 0;
   int   results_seen = 0;
   int   tx_gap       = 0;
   int   rx_stall     = 0;
   int   quiet_cycles = 0;
   logic tx_idle_on   = 1'b1;
   logic rx_idle_on   = 1'b1;
   logic tx_valid_next;

   logic [7:0] near_letters [4] = '{8'h40, 8'h5B, 8'h60, 8'h7B};

   byte_pattern_replacer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   task automatic emit_out(input logic [7:0] data, input logic replaced);
      out_byte_type r;
      r.data     = data;
      r.last     = 1'b0;
      r.done     = 1'b0;
      r.replaced = replaced;
      r.limit    = limit_flag;
      out_bytes_due.push_back(r);
   endtask

   task automatic drop_front(input int n);
      int j;
      if (n >= win_fill) begin
         win_fill = 0;
      end else begin
         for (j = 0; j < win_fill - n; j++) win_bytes[j] = win_bytes[j + n];
         win_fill -= n;
      end
   endtask

   // Advance the window by one input byte and queue the output bytes it frees
   task automatic replace_step(input logic [7:0] b, input logic eos);
      logic         en;
      logic         hit;
      logic         swapped;
      logic [7:0]   wb;
      logic [7:0]   nb;
      int           len;
      int           k;
      int           i;
      out_byte_type tail;
      en  = (cfg_old_len >= 1) && (cfg_old_len <= MAX_BYTES) &&
            (cfg_new_len >= 1) && (cfg_new_len <= cfg_old_len);
      len = en ? int'(cfg_old_len) : 1;
      k   = 0;
      if (win_fill < MAX_BYTES) begin
         win_bytes[win_fill] = b;
         win_fill++;
      end
      while (win_fill > 0 && win_fill >= len) begin
         swapped = 1'b0;
         if (en) begin
            hit = 1'b1;
            for (i = 0; i < len; i++) begin
               wb = win_bytes[i];
               nb = cfg_old_pat[8*i +: 8];
               if (cfg_case_sens ? (wb != nb) : (to_lower(wb) != to_lower(nb))) hit = 1'b0;
            end
            if (hit) begin
               if (cfg_max_repl != 0 && repl_count >= cfg_max_repl) begin
                  limit_flag = 1'b1;
               end else begin
                  for (i = 0; i < int'(cfg_new_len); i++) begin
                     nb = cfg_new_pat[8*i +: 8];
                     // copy the case of the overwritten byte
                     if (!cfg_case_sens) begin
                        if (win_bytes[i] >= 8'h41 && win_bytes[i] <= 8'h5A)
                           nb = (nb >= 8'h61 && nb <= 8'h7A) ? nb - 8'd32 : nb;
                        else
                           nb = to_lower(nb);
                     end
                     win_bytes[i] = nb;
                  end
                  for (i = 0; i < len; i++) emit_out(win_bytes[i], 1'b1);
                  k += len;
                  repl_count++;
                  drop_front(len);
                  swapped = 1'b1;
               end
            end
         end
         if (!swapped) begin
            emit_out(win_bytes[0], 1'b0);
            k++;
            drop_front(1);
         end
      end
      if (eos) begin
         for (i = 0; i < win_fill; i++) emit_out(win_bytes[i], 1'b0);
         k += win_fill;
         win_fill = 0;
      end
      if (k > 0) begin
         tail      = out_bytes_due.pop_back();
         tail.last = 1'b1;
         tail.done = eos;
         out_bytes_due.push_back(tail);
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d: %s is %0h, predicted %0h",
                                   results_seen, name, got, want));
   endtask

   // Driver: hold a presented byte until its transfer, then pick the next
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            replace_step(req_tdata, req_tlast);
            void'(in_bytes_queued.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            tx_valid_next = 1'b0;
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (in_bytes_queued.size() != 0 &&
                         !(in_bytes_queued[0].hold && out_bytes_due.size() != 0)) begin
               if (tx_idle_on && $urandom_range(0, 5) == 0) begin
                  tx_gap = $urandom_range(0, 13);
               end else begin
                  tx_valid_next = 1'b1;
                  req_tdata <= in_bytes_queued[0].data;
                  req_tlast <= in_bytes_queued[0].eos;
               end
            end
            req_tvalid <= tx_valid_next;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_stall > 0) begin
         rx_stall--;
         rsp_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
         rx_stall = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: compare each output transfer with the oldest due byte
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (out_bytes_due.size() == 0) begin
            report_mismatch($sformatf("result %0d: byte %02h with nothing due",
                                      results_seen, rsp_tdata));
         end else begin
            due_out = out_bytes_due.pop_front();
            check_field("out_byte", rsp_tdata, due_out.data);
            check_field("last_of_run", rsp_tlast, due_out.last);
            check_field("stream_done", rsp_tuser[0], due_out.done);
            check_field("was_replaced", rsp_tuser[1], due_out.replaced);
            check_field("limit_reached", rsp_tuser[2], due_out.limit);
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic [7:0] data, input logic eos, input logic hold);
      in_byte_type item;
      item.data = data;
      item.eos  = eos;
      item.hold = hold;
      in_bytes_queued.push_back(item);
   endtask

   task automatic push_text(input string s, input logic eos_end);
      int i;
      for (i = 0; i < s.len(); i++)
         push_byte(s[i], eos_end && (i == s.len() - 1), 1'b0);
   endtask

   task automatic wait_drained();
      while (in_bytes_queued.size() != 0 || req_tvalid || out_bytes_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all six registers on back-to-back edges; upper bits of narrow fields are junk
   task automatic write_config(input logic [PAT_W-1:0] op, input logic [LEN_W-1:0] ol,
                               input logic [PAT_W-1:0] np, input logic [LEN_W-1:0] nl,
                               input logic cs, input logic [LIMIT_W-1:0] mx);
      logic [CSR_DATA_W-1:0] junk;
      junk = {$urandom, $urandom};
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= CSR_OLD_PATTERN;
      csr_wdata <= op;
      @(posedge clock);
      csr_index <= CSR_OLD_LENGTH;
      csr_wdata <= {junk[CSR_DATA_W-1:LEN_W], ol};
      @(posedge clock);
      csr_index <= CSR_NEW_PATTERN;
      csr_wdata <= np;
      @(posedge clock);
      csr_index <= CSR_NEW_LENGTH;
      csr_wdata <= {junk[CSR_DATA_W-1:LEN_W], nl};
      @(posedge clock);
      csr_index <= CSR_CASE_SENSITIVE;
      csr_wdata <= {junk[CSR_DATA_W-1:1], cs};
      @(posedge clock);
      csr_index <= CSR_MAX_REPLACEMENTS;
      csr_wdata <= {junk[CSR_DATA_W-1:LIMIT_W], mx};
      @(posedge clock);
      csr_wen <= 1'b0;
      cfg_old_pat   = op;
      cfg_old_len   = ol;
      cfg_new_pat   = np;
      cfg_new_len   = nl;
      cfg_case_sens = cs;
      cfg_max_repl  = mx;
      @(negedge clock);
   endtask

   // Letters of either case, the neighbors of the letter ranges, or anything
   function automatic logic [7:0] pick_pat_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 4)
         return (8'h61 + 8'($urandom_range(0, 25))) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
      else if (r == 5)
         return near_letters[$urandom_range(0, 3)];
      else
         return 8'($urandom_range(0, 255));
   endfunction

   task automatic pick_config(input logic force_enabled);
      logic [PAT_W-1:0]   op;
      logic [PAT_W-1:0]   np;
      logic [LIMIT_W-1:0] mx;
      int                 kind;
      int                 olen;
      int                 nlen;
      int                 i;
      kind = force_enabled ? 9 : $urandom_range(0, 9);
      case (kind)
         0: begin
            olen = 0;
            nlen = $urandom_range(0, 15);
         end
         1: begin
            olen = $urandom_range(MAX_BYTES + 1, 15);
            nlen = $urandom_range(0, 15);
         end
         2: begin
            olen = $urandom_range(1, MAX_BYTES);
            nlen = 0;
         end
         3: begin
            olen = $urandom_range(1, MAX_BYTES - 1);
            nlen = $urandom_range(olen + 1, 15);
         end
         default: begin
            olen = $urandom_range(1, MAX_BYTES);
            nlen = $urandom_range(1, olen);
         end
      endcase
      for (i = 0; i < MAX_BYTES; i++) begin
         op[8*i +: 8] = pick_pat_byte();
         np[8*i +: 8] = pick_pat_byte();
      end
      case ($urandom_range(0, 5))
         3:       mx = repl_count + $urandom_range(1, 4);
         4:       mx = repl_count;
         5:       mx = $urandom | 32'h8000_0000;
         default: mx = '0;
      endcase
      write_config(op, LEN_W'(olen), np, LEN_W'(nlen), 1'($urandom_range(0, 1)), mx);
   endtask

   // Mostly whole or partial occurrences of the search pattern, some noise
   task automatic queue_stream(input int count, input logic hold_mid, input logic eos_end);
      logic [7:0]  b;
      int          plen;
      int          made;
      int          choice;
      int          cut;
      int          i;
      in_byte_type tail;
      plen = (cfg_old_len >= 1 && cfg_old_len <= MAX_BYTES) ? int'(cfg_old_len)
                                                            : $urandom_range(1, MAX_BYTES);
      made = 0;
      while (made < count) begin
         choice = $urandom_range(0, 9);
         if (choice <= 3)      cut = plen;
         else if (choice <= 5) cut = $urandom_range(1, plen);
         else if (choice == 6) cut = 1;
         else                  cut = 0;
         if (cut == 0) begin
            i = $urandom_range(0, MAX_BYTES - 1);
            b = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : cfg_old_pat[8*i +: 8];
            push_byte(b, $urandom_range(0, 29) == 0, hold_mid && made == count / 2);
            made++;
         end
         for (i = 0; i < cut && made < count; i++) begin
            b = cfg_old_pat[8*i +: 8];
            if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(0, 2) == 0)
               b = b ^ 8'h20;
            push_byte(b, $urandom_range(0, 29) == 0, hold_mid && made == count / 2);
            made++;
         end
      end
      if (eos_end) begin
         tail     = in_bytes_queued.pop_back();
         tail.eos = 1'b1;
         in_bytes_queued.push_back(tail);
      end
   endtask

   initial begin
      int p;
      int i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings leave replacement off: extremes pass straight through
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b1, 1'b0);
      wait_drained();

      // exact match, shorter replacement, back-to-back occurrences
      write_config(64'h63_62_61, 4'd3, 64'h59_58, 4'd2, 1'b1, 32'd0);
      push_text("zabcabc", 1'b1);
      wait_drained();

      // folded match with case copying, top limit value
      write_config(64'h43_62_41, 4'd3, 64'h7A_79_78, 4'd3, 1'b0, 32'hFFFF_FFFF);
      push_text("aBc@", 1'b1);
      wait_drained();

      // limit already used up: match goes out untouched and the flag sticks
      write_config(64'h63_62_61, 4'd3, 64'h59_58, 4'd2, 1'b1, 32'd1);
      push_text("abc", 1'b1);
      wait_drained();

      // full-width pattern, one input frees the largest burst
      write_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0, 4'd8, 1'b1, 32'd0);
      for (i = 0; i < MAX_BYTES; i++) push_byte(8'hFF, 1'b0, 1'b0);
      wait_drained();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         pick_config(p == 0);
         tx_idle_on = $urandom_range(0, 3) != 0;
         rx_idle_on = $urandom_range(0, 3) != 0;
         // open streams carry the window into the next settings
         queue_stream(PHASE_ITEMS, p == 0 || $urandom_range(0, 2) == 0,
                      1'($urandom_range(0, 1)));
         wait_drained();
      end

      // run out at full rate
      pick_config(1'b1);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      queue_stream(PHASE_ITEMS, 1'b0, 1'b1);
      wait_drained();

      repeat (20) @(posedge clock);
      if (out_bytes_due.size() != 0)
         report_mismatch($sformatf("%0d output bytes never arrived", out_bytes_due.size()));
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
